/* rtl/core/fts_pkg.sv */
// Shared types and constants for the frequency table select block.
package fts_pkg;

  // Fixed field widths at the block boundary
  localparam int unsigned KHZ_W      = 32;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned IDX_IN_W   = 4;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Item kinds
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SELECT = 1'b1;

  // Register index taken from paddr[2]
  localparam logic REG_ENTRY_COUNT = 1'b0;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_wr;    // write one table entry
    logic sel_start;  // latch a select item and clear the accumulators
    logic rd_en;      // read the next table entry of the scan
    logic res_load;   // move the finished result into the output register
  } fts_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic sel_skip;   // window inverted or nothing to scan
    logic scan_last;  // the current read is the last entry to scan
    logic out_free;   // output register can take a result this cycle
  } fts_stat_t;

endpackage

/* rtl/core/fts_ctrl.sv */
// Controller state machine that sequences loads, table scans and results.
module fts_ctrl
  import fts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      mode_i,
  input  fts_stat_t stat_i,
  output fts_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;
  logic       accept;

  // Take an item only while no select is in flight
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Drive datapath commands
  assign cmd_o.load_wr   = accept && (mode_i == MODE_LOAD);
  assign cmd_o.sel_start = accept && (mode_i == MODE_SELECT);
  assign cmd_o.rd_en     = (state_q == ST_SCAN);
  assign cmd_o.res_load  = (state_q == ST_FINISH) && stat_i.out_free;

  // Advance the sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.sel_start) begin
          state_d = stat_i.sel_skip ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/fts_dpath.sv */
// Datapath: frequency table memory, scan accumulators and output register.
module fts_dpath
  import fts_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned FREQ_WIDTH  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fts_cmd_t            cmd_i,
  output fts_stat_t           stat_o,
  input  logic [COUNT_W-1:0]  entry_count_i,
  input  logic [IDX_IN_W-1:0] entry_index_i,
  input  logic [KHZ_W-1:0]    entry_khz_i,
  input  logic [KHZ_W-1:0]    requested_khz_i,
  input  logic [KHZ_W-1:0]    window_min_khz_i,
  input  logic [KHZ_W-1:0]    window_max_khz_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                status_o,
  output logic [KHZ_W-1:0]    selected_khz_o
);

  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int unsigned IEXT_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

  logic [FREQ_WIDTH-1:0] mem_q [TABLE_DEPTH];
  logic [FREQ_WIDTH-1:0] rd_data_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      addr_q;
  logic [IDX_W-1:0]      last_q;
  logic [FREQ_WIDTH-1:0] req_q;
  logic [FREQ_WIDTH-1:0] lo_q;
  logic [FREQ_WIDTH-1:0] hi_q;
  logic [FREQ_WIDTH-1:0] best_q;
  logic [FREQ_WIDTH-1:0] lowest_q;
  logic                  out_vld_q;
  logic                  out_status_q;
  logic [KHZ_W-1:0]      out_khz_q;

  logic [FREQ_WIDTH-1:0] req_in;
  logic [FREQ_WIDTH-1:0] lo_in;
  logic [FREQ_WIDTH-1:0] hi_in;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      depth_ext;
  logic [CMP_W-1:0]      scan_n;
  logic [CMP_W-1:0]      scan_n_m1;
  logic [IEXT_W-1:0]     idx_ext;
  logic                  idx_ok;
  logic [IDX_W-1:0]      wr_addr;
  logic                  qual;
  logic [FREQ_WIDTH-1:0] pick;

  // Bring input fields to the internal frequency width
  assign req_in = FREQ_WIDTH'(requested_khz_i);
  assign lo_in  = FREQ_WIDTH'(window_min_khz_i);
  assign hi_in  = FREQ_WIDTH'(window_max_khz_i);

  // Clamp the scan length to the table depth
  assign cnt_ext   = CMP_W'(entry_count_i);
  assign depth_ext = CMP_W'(TABLE_DEPTH);
  assign scan_n    = (cnt_ext > depth_ext) ? depth_ext : cnt_ext;
  assign scan_n_m1 = scan_n - CMP_W'(1);

  // Drop loads aimed past the table
  assign idx_ext = IEXT_W'(entry_index_i);
  assign idx_ok  = (idx_ext < IEXT_W'(TABLE_DEPTH));
  assign wr_addr = idx_ext[IDX_W-1:0];

  // Report status to the controller
  assign stat_o.sel_skip  = (lo_in > hi_in) || (scan_n == '0);
  assign stat_o.scan_last = (addr_q == last_q);
  assign stat_o.out_free  = !out_vld_q || !out_stall_i;

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && idx_ok) begin
      mem_q[wr_addr] <= FREQ_WIDTH'(entry_khz_i);
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[addr_q];
    end
  end

  // Qualify the entry read in the previous cycle
  assign qual = (rd_data_q != '0) && (rd_data_q >= lo_q) && (rd_data_q <= hi_q);

  // Latch the request, step the scan address and accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      addr_q   <= '0;
      last_q   <= '0;
      req_q    <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      best_q   <= '0;
      lowest_q <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.sel_start) begin
        addr_q   <= '0;
        last_q   <= scan_n_m1[IDX_W-1:0];
        req_q    <= req_in;
        lo_q     <= lo_in;
        hi_q     <= hi_in;
        best_q   <= '0;
        lowest_q <= '0;
      end else begin
        if (cmd_i.rd_en) begin
          addr_q <= addr_q + IDX_W'(1);
        end
        if (rd_vld_q && qual) begin
          if ((rd_data_q <= req_q) && (rd_data_q > best_q)) begin
            best_q <= rd_data_q;
          end
          if ((lowest_q == '0) || (rd_data_q < lowest_q)) begin
            lowest_q <= rd_data_q;
          end
        end
      end
    end
  end

  // Prefer the best entry at or under the request, else the lowest in window
  assign pick = (best_q != '0) ? best_q : lowest_q;

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q    <= 1'b0;
      out_status_q <= 1'b0;
      out_khz_q    <= '0;
    end else if (cmd_i.res_load) begin
      out_vld_q    <= 1'b1;
      out_status_q <= (pick == '0);
      out_khz_q    <= KHZ_W'(pick);
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_status_q;
  assign selected_khz_o = out_khz_q;

  // A new result never overwrites one that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> !(out_vld_q && out_stall_i))
    else $error("result loaded over a stalled result");

  // The scan never reads past the clamped entry count
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> (addr_q <= last_q))
    else $error("scan address beyond entry count");

  // The best-below candidate never exceeds the request
  a_best_below_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_q != '0) |-> (best_q <= req_q))
    else $error("best candidate above request");

  // An invalid result carries a zero frequency
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q) |-> (out_khz_q == '0))
    else $error("invalid status with nonzero frequency");

endmodule

/* rtl/core/frequency_table_select.sv */
// Top level of the frequency table select block: register port and wiring.
//
// A load item writes one table entry when it is taken; it gives no result. A
// select item scans table entries 0 to entry_count-1 (clamped to TABLE_DEPTH)
// through the single read port of the table memory, one entry per cycle: it is
// accepted, reads each entry in turn, does the last compare and then loads the
// output register, or goes from acceptance straight to loading the output
// register when the window is inverted or the count is zero. No item is taken
// from the cycle after a select is accepted until its result moves into the
// output register, which also waits while an earlier result is still stalled
// downstream. The result sits in an output register, so load items are still
// taken while it waits downstream.
// Table entries are undefined until loaded: only select over written entries.
module frequency_table_select
  import fts_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned FREQ_WIDTH  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input items
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [IDX_IN_W-1:0]   entry_index_i,
  input  logic [KHZ_W-1:0]      entry_khz_i,
  input  logic [KHZ_W-1:0]      requested_khz_i,
  input  logic [KHZ_W-1:0]      window_min_khz_i,
  input  logic [KHZ_W-1:0]      window_max_khz_i,
  // Result items
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  status_o,
  output logic [KHZ_W-1:0]      selected_khz_o,
  // Register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  fts_cmd_t           cmd;
  fts_stat_t          stat;
  logic [COUNT_W-1:0] entry_count_q;
  logic               reg_wr;

  // Decode register writes
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (reg_wr) begin
      entry_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  // Return the register on reads
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ENTRY_COUNT: prdata = APB_DATA_W'(entry_count_q);
      default:         prdata = '0;
    endcase
  end

  fts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fts_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FREQ_WIDTH  (FREQ_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .entry_count_i    (entry_count_q),
    .entry_index_i    (entry_index_i),
    .entry_khz_i      (entry_khz_i),
    .requested_khz_i  (requested_khz_i),
    .window_min_khz_i (window_min_khz_i),
    .window_max_khz_i (window_max_khz_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .selected_khz_o   (selected_khz_o)
  );

endmodule
